// File: src/sdbe_pkg.sv
// Shared types and constants for the stuffed differential bit encoder.
package sdbe_pkg;

  localparam int BYTE_BITS = 8;
  localparam int IDX_W     = 6;
  localparam int BIT_IDX_W = $clog2(BYTE_BITS);
  localparam int RUN_W     = 3;

  // Run of ones that forces a stuffed zero, and first byte of the stuffing region.
  localparam logic [RUN_W-1:0] STUFF_RUN        = 3'd5;
  localparam logic [IDX_W-1:0] STUFF_FIRST_BYTE = 6'd4;
  // Bytes at the end of the frame that lie outside the stuffing region.
  localparam logic [IDX_W:0]   STUFF_TAIL_BYTES = 7'd2;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TRAILER = 1'b1;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic                 command;
    logic                 frame_start;
    logic                 in_region;
    logic [BYTE_BITS-1:0] data_byte;
  } item_t;

endpackage

// File: src/sdbe_front.sv
// Front end: accepts input transfers and classifies the stuffing region.
module sdbe_front (
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic                         command,
  input  logic [sdbe_pkg::BYTE_BITS-1:0] data_byte,
  input  logic [sdbe_pkg::IDX_W-1:0]   byte_index,
  input  logic [sdbe_pkg::IDX_W-1:0]   frame_length,
  input  logic                         frame_start,
  input  logic                         q_full,
  output logic                         q_push,
  output sdbe_pkg::item_t              q_item
);

  logic [sdbe_pkg::IDX_W:0] idx_tail;

  assign idx_tail = {1'b0, byte_index} + sdbe_pkg::STUFF_TAIL_BYTES;

  assign s_ready = !q_full;
  assign q_push  = s_valid && !q_full;

  always_comb begin
    q_item.command     = command;
    q_item.frame_start = frame_start;
    q_item.data_byte   = data_byte;
    q_item.in_region   = (byte_index >= sdbe_pkg::STUFF_FIRST_BYTE) &&
                         (idx_tail <= {1'b0, frame_length});
  end

endmodule

// File: src/sdbe_queue.sv
// Short queue of classified items between front and back.
module sdbe_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sdbe_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sdbe_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sdbe_pkg::item_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_item = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/sdbe_back.sv
// Back end: one line-coded bit per cycle into an output register, unless it stalls.
module sdbe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  sdbe_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            first_half_level,
  output logic            second_half_level,
  output logic            stuffed,
  output logic            last
);

  localparam logic [sdbe_pkg::BIT_IDX_W-1:0] LAST_BIT =
    sdbe_pkg::BIT_IDX_W'(sdbe_pkg::BYTE_BITS - 1);

  sdbe_pkg::item_t                   item;
  logic                              active;
  logic                              active_next;
  logic [sdbe_pkg::BIT_IDX_W-1:0]    bit_idx;
  logic [sdbe_pkg::BIT_IDX_W-1:0]    bit_idx_next;
  logic                              stuff_pend;
  logic                              stuff_pend_next;
  logic                              line_level;
  logic                              line_level_next;
  logic [sdbe_pkg::RUN_W-1:0]        ones_run;
  logic [sdbe_pkg::RUN_W-1:0]        ones_run_next;
  logic [sdbe_pkg::RUN_W-1:0]        ones_upd;
  logic                              advance;
  logic                              finish;
  logic                              cur_bit;
  logic                              lvl_in;
  logic                              res_first;
  logic                              res_second;
  logic                              res_stuffed;
  logic                              res_last;

  assign advance = active && (!out_valid || out_ready);
  assign q_pop   = q_not_empty && (!active || (advance && finish));
  assign cur_bit = item.data_byte[bit_idx];
  // Frame start presets the line high just before the first data bit.
  assign lvl_in  = (bit_idx == '0 && !stuff_pend && item.frame_start) ? 1'b1 : line_level;

  always_comb begin
    finish          = 1'b0;
    bit_idx_next    = bit_idx;
    stuff_pend_next = stuff_pend;
    line_level_next = line_level;
    ones_run_next   = ones_run;
    ones_upd        = ones_run;
    res_first       = 1'b0;
    res_second      = 1'b0;
    res_stuffed     = 1'b0;
    res_last        = 1'b0;
    if (item.command == sdbe_pkg::CMD_TRAILER) begin
      res_first       = 1'b1;
      res_second      = 1'b1;
      res_last        = 1'b1;
      line_level_next = 1'b0;
      finish          = 1'b1;
    end else if (stuff_pend) begin
      res_first       = !line_level;
      res_second      = !line_level;
      res_stuffed     = 1'b1;
      line_level_next = !line_level;
      stuff_pend_next = 1'b0;
      res_last        = (bit_idx == LAST_BIT);
      finish          = (bit_idx == LAST_BIT);
      bit_idx_next    = bit_idx + 1'b1;
    end else begin
      res_first       = !lvl_in;
      res_second      = !lvl_in ^ cur_bit;
      line_level_next = !lvl_in ^ cur_bit;
      if (cur_bit) begin
        ones_upd = item.in_region ? ones_run + 1'b1 : ones_run;
      end else begin
        ones_upd = '0;
      end
      if (ones_upd >= sdbe_pkg::STUFF_RUN) begin
        // Hold the bit index; the stuffed zero goes out next.
        stuff_pend_next = 1'b1;
        ones_run_next   = '0;
      end else begin
        ones_run_next = ones_upd;
        res_last      = (bit_idx == LAST_BIT);
        finish        = (bit_idx == LAST_BIT);
        bit_idx_next  = bit_idx + 1'b1;
      end
    end
  end

  always_comb begin
    active_next = active;
    if (q_pop) begin
      active_next = 1'b1;
    end else if (advance && finish) begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (advance) begin
      first_half_level  <= res_first;
      second_half_level <= res_second;
      stuffed           <= res_stuffed;
      last              <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      bit_idx    <= '0;
      stuff_pend <= 1'b0;
      line_level <= 1'b0;
      ones_run   <= '0;
      out_valid  <= 1'b0;
    end else begin
      active <= active_next;
      if (advance) begin
        line_level <= line_level_next;
        ones_run   <= ones_run_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        bit_idx    <= '0;
        stuff_pend <= 1'b0;
      end else if (advance) begin
        bit_idx    <= bit_idx_next;
        stuff_pend <= stuff_pend_next;
      end
    end
  end

endmodule

// File: src/stuffed_differential_bit_encoder.sv
// Top level of the stuffed differential bit encoder.
//
//  channel  | direction | carries
//  s_axis   | in        | byte or trailer command with frame position
//  m_axis   | out       | one line-coded bit (two half levels) per transfer
//
// A byte gives 8 to 10 output transfers, one per cycle unless the output stalls, set
// by the bit serializer in the back end; a trailer gives one. The next item loads in the
// cycle the previous one's final bit goes out, so there is no gap between queued items.
// Reset (synchronous) clears the queue, the line level (low) and the ones run.
// A stalled output holds in its register; input stalls only when the queue fills.
module stuffed_differential_bit_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], byte_index[13:8], frame_length[19:14]
  input  logic [1:0]  s_axis_tuser,  // command[0], frame_start[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // first_half_level[0], second_half_level[1]
  output logic        m_axis_tuser,  // stuffed[0]
  output logic        m_axis_tlast
);

  sdbe_pkg::item_t push_item;
  sdbe_pkg::item_t head_item;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_not_empty;
  logic            first_half_level;
  logic            second_half_level;

  sdbe_front u_front (
    .s_valid      (s_axis_tvalid),
    .s_ready      (s_axis_tready),
    .command      (s_axis_tuser[0]),
    .data_byte    (s_axis_tdata[7:0]),
    .byte_index   (s_axis_tdata[13:8]),
    .frame_length (s_axis_tdata[19:14]),
    .frame_start  (s_axis_tuser[1]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  sdbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  sdbe_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_not_empty       (q_not_empty),
    .q_item            (head_item),
    .q_pop             (q_pop),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .first_half_level  (first_half_level),
    .second_half_level (second_half_level),
    .stuffed           (m_axis_tuser),
    .last              (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, second_half_level, first_half_level};

endmodule

// File: src/sdbe_checker.sv
// Port-level checks for the stuffed differential bit encoder, bound to the top level.
module sdbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled output transfer.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  // A stuffed zero has no mid-bit toggle.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0] == m_axis_tdata[1])
    else $error("stuffed bit toggles at mid-bit");

  // Padding bits stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'b0)
    else $error("output padding not zero");

  // Reset empties the output register.
  assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind stuffed_differential_bit_encoder sdbe_checker u_sdbe_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: bench/stuffed_differential_bit_encoder_test.sv
// Self-checking bench for the stuffed differential bit encoder stream block.
module stuffed_differential_bit_encoder_test;

  localparam int MAX_GAP     = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_GOAL   = 370;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic first_half;
    logic second_half;
    logic stuffed;
    logic last;
  } line_bit_t;

  // Tracks line level and ones run, and holds the bits still owed by the block.
  class line_bit_scoreboard;
    logic                           line_lvl = 1'b0;
    logic [sdbe_pkg::RUN_W-1:0]     ones_run = '0;
    line_bit_t                      owed_bits[$];
    int                             error_count = 0;

    task flag_error(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    function int pending();
      return owed_bits.size();
    endfunction

    // Toggle at bit start, toggle again mid-bit for a one.
    function line_bit_t code_bit(logic value, logic stuffed_bit, logic last_bit);
      line_bit_t b;
      line_lvl = ~line_lvl;
      b.first_half = line_lvl;
      if (value) line_lvl = ~line_lvl;
      b.second_half = line_lvl;
      b.stuffed = stuffed_bit;
      b.last = last_bit;
      return b;
    endfunction

    function void note_item(logic cmd, logic [sdbe_pkg::BYTE_BITS-1:0] data,
                            logic [sdbe_pkg::IDX_W-1:0] idx,
                            logic [sdbe_pkg::IDX_W-1:0] flen, logic start);
      logic      counting;
      logic      value;
      logic      stuff_now;
      line_bit_t data_bit;
      if (cmd == sdbe_pkg::CMD_TRAILER) begin
        owed_bits.push_back(line_bit_t'{1'b1, 1'b1, 1'b0, 1'b1});
        line_lvl = 1'b0;
        return;
      end
      if (start) line_lvl = 1'b1;
      counting = (idx >= sdbe_pkg::STUFF_FIRST_BYTE) &&
                 (int'(idx) + int'(sdbe_pkg::STUFF_TAIL_BYTES) <= int'(flen));
      for (int n = 0; n < sdbe_pkg::BYTE_BITS; n++) begin
        value = data[n];
        data_bit = code_bit(value, 1'b0, 1'b0);
        if (value) begin
          if (counting) ones_run = ones_run + 1'b1;
        end else begin
          ones_run = '0;
        end
        stuff_now = (ones_run >= sdbe_pkg::STUFF_RUN);
        data_bit.last = (n == sdbe_pkg::BYTE_BITS - 1) && !stuff_now;
        owed_bits.push_back(data_bit);
        if (stuff_now) begin
          owed_bits.push_back(code_bit(1'b0, 1'b1, n == sdbe_pkg::BYTE_BITS - 1));
          ones_run = '0;
        end
      end
    endfunction

    task check_bit(logic first_half, logic second_half, logic stuffed, logic last);
      line_bit_t want;
      if (owed_bits.size() == 0) begin
        flag_error($sformatf("bit with none pending: %b%b stuffed=%b last=%b",
                             first_half, second_half, stuffed, last));
        return;
      end
      want = owed_bits.pop_front();
      if (first_half !== want.first_half)
        flag_error($sformatf("first half %b, want %b", first_half, want.first_half));
      if (second_half !== want.second_half)
        flag_error($sformatf("second half %b, want %b", second_half, want.second_half));
      if (stuffed !== want.stuffed)
        flag_error($sformatf("stuffed %b, want %b", stuffed, want.stuffed));
      if (last !== want.last)
        flag_error($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // data_byte[7:0], byte_index[13:8], frame_length[19:14]
  logic [1:0]  s_axis_tuser = '0;  // command[0], frame_start[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // first_half_level[0], second_half_level[1]
  logic        m_axis_tuser;       // stuffed[0]
  logic        m_axis_tlast;

  line_bit_scoreboard sb = new;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_off_req = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;

  stuffed_differential_bit_encoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_bit(m_axis_tdata[0], m_axis_tdata[1], m_axis_tuser, m_axis_tlast);
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : bit_sink
    int wait_n;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      wait_n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_item(logic cmd, logic [7:0] data, logic [5:0] idx, logic [5:0] flen,
                           logic start);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, flen, idx, data};
    s_axis_tuser  <= {start, cmd};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, data, idx, flen, start);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return 8'hFF;
      2: return 8'($urandom_range(0, 255) | $urandom_range(0, 255));
      default: return ~(8'h01 << $urandom_range(0, 7));
    endcase
  endfunction

  // Well-formed frame: bytes 1..length, start on the first, usually a trailer.
  task automatic send_frame();
    logic [5:0] flen;
    flen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(4, 32)) : 6'($urandom_range(4, 12));
    for (int i = 1; i <= flen; i++)
      send_item(sdbe_pkg::CMD_BYTE, pick_byte(), 6'(i), flen, i == 1);
    if ($urandom_range(0, 9) != 0)
      send_item(sdbe_pkg::CMD_TRAILER, 8'($urandom), 6'($urandom), 6'($urandom),
                1'($urandom));
  endtask

  task automatic send_noise();
    send_item(1'($urandom), 8'($urandom), 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    int phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // trailer straight out of reset, then idle-line bytes
    send_item(sdbe_pkg::CMD_TRAILER, 8'h00, 6'd0, 6'd0, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'h00, 6'd1, 6'd4, 1'b1);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd1, 6'd4, 1'b0);
    send_item(sdbe_pkg::CMD_TRAILER, 8'hFF, 6'd63, 6'd63, 1'b1);
    // frame of eight: stuffing inside the region, none in the tail
    send_item(sdbe_pkg::CMD_BYTE, 8'hAA, 6'd1, 6'd8, 1'b1);
    send_item(sdbe_pkg::CMD_BYTE, 8'h55, 6'd2, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd3, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd4, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd5, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hF8, 6'd6, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd7, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'h00, 6'd8, 6'd8, 1'b0);
    send_item(sdbe_pkg::CMD_TRAILER, 8'h00, 6'd0, 6'd0, 1'b0);
    // short frames and out-of-range positions
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd0, 6'd0, 1'b1);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd4, 6'd1, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd63, 6'd2, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd63, 6'd63, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'h00, 6'd3, 6'd32, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'hFF, 6'd61, 6'd63, 1'b0);
    // ones run carries across a trailer and a new frame start
    send_item(sdbe_pkg::CMD_BYTE, 8'hF0, 6'd4, 6'd10, 1'b0);
    send_item(sdbe_pkg::CMD_TRAILER, 8'hFF, 6'd4, 6'd10, 1'b0);
    send_item(sdbe_pkg::CMD_BYTE, 8'h03, 6'd4, 6'd10, 1'b1);
    send_item(sdbe_pkg::CMD_BYTE, 8'h7F, 6'd32, 6'd32, 1'b1);

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      // drop valid and pause until the block has drained
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
      tx_idle = (phase % 3) != 0 && $urandom_range(0, 1);
      rx_idle = (phase % 4) != 1 && $urandom_range(0, 1);
      if (phase == 3) begin
        tx_idle = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat ($urandom_range(1, 3)) begin
        send_frame();
        repeat ($urandom_range(0, 2)) send_noise();
      end
      phase++;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
